// ----- rtl/sha256_byte_stream_hasher_macros.svh -----
// assertion macros for the sha256 byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH
// assert that an antecedent implies a consequent in the same cycle
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// assert that an antecedent implies a consequent in the next cycle
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/sha_pkg.sv -----
// package with sha-256 constants, types and a rotate function
package sha_pkg;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(logic [31:0] v, int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction
endpackage

// ----- rtl/sha_if.sv -----
// valid-ready channel interfaces for input and output transactions
interface sha_in_if;
  logic             valid;
  logic             ready;
  sha_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if;
  logic              valid;
  logic              ready;
  sha_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/sha_queue.sv -----
// front part: accepts input transactions and queues the ones that matter
module sha_queue #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sha_in_if.sink            in_if,
  output logic              q_valid_o,
  output sha_pkg::in_item_t q_item_o,
  input  logic              q_pop_i
);
  import sha_pkg::*;
  `include "sha256_byte_stream_hasher_macros.svh"

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  in_item_t          mem_q [Depth];
  logic [Aw-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [Aw:0]       cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign in_if.ready = (cnt_q != Aw'(0) + (Aw+1)'(Depth));
  // items with neither byte nor end are dropped
  assign push = in_if.valid && in_if.ready &&
                (in_if.payload.byte_valid || in_if.payload.end_of_message);
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_pop_i && q_valid_o;
  assign q_item_o = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push) wr_d = (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + Aw'(1);
    if (pop) rd_d = (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + Aw'(1);
    cnt_d = cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_if.payload;
  end

  `SHA_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push, cnt_q < (Aw+1)'(Depth))
  `SHA_ASSERT_NEXT(a_cnt_up, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
  `SHA_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop, cnt_q != '0)
endmodule

// ----- rtl/sha_core.sv -----
// back part: block assembly, padding, compression and digest output
module sha_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  sha_pkg::in_item_t    q_item_i,
  output logic                 q_pop_o,
  sha_out_if.source            out_if
);
  import sha_pkg::*;
  `include "sha256_byte_stream_hasher_macros.svh"

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StPad   = 5'b00010,
    StRound = 5'b00100,
    StAdd   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e      st_q, st_d;
  logic [31:0] h_q [8];
  logic [31:0] r_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  fill_q;
  logic [60:0] len_q;
  logic [5:0]  rnd_q;
  logic        fin_q;
  logic        eom_q;
  logic        pad80_q;
  logic        lenblk_q;
  logic [2:0]  oidx_q;
  logic [63:0] bits;
  logic [63:0] len_shift;
  logic [7:0]  pad_byte;
  logic        put;
  logic [7:0]  put_byte;
  logic [31:0] t1, t2, s0, s1, wn, wr;

  assign bits = {len_q, 3'b000};
  assign len_shift = bits >> {~fill_q[2:0], 3'b000};
  always_comb begin
    if (!pad80_q) pad_byte = 8'h80;
    else if (lenblk_q && fill_q >= 6'd56) pad_byte = len_shift[7:0];
    else pad_byte = 8'h00;
  end

  // lenblk_q marks the block that carries the bit length
  assign q_pop_o = (st_q == StIdle) && q_valid_i;
  assign put = q_pop_o && q_item_i.byte_valid;
  assign put_byte = (st_q == StPad) ? pad_byte : q_item_i.data_byte;

  assign wr = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]] : wn;
  assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wn = s1 + w_q[9] + s0 + w_q[0];
  assign t1 = r_q[7] + (rotr(r_q[4], 6) ^ rotr(r_q[4], 11) ^ rotr(r_q[4], 25)) +
              ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6])) + RoundK[rnd_q] + wr;
  assign t2 = (rotr(r_q[0], 2) ^ rotr(r_q[0], 13) ^ rotr(r_q[0], 22)) +
              ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (q_pop_o) begin
        if (put && fill_q == 6'd63) st_d = StRound;
        else if (q_item_i.end_of_message) st_d = StPad;
      end
      StPad: if (fill_q == 6'd63) st_d = StRound;
      StRound: if (rnd_q == 6'd63) st_d = StAdd;
      StAdd: st_d = fin_q ? StOut : (eom_q ? StPad : StIdle);
      StOut: if (out_if.ready && oidx_q == 3'd7) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      fill_q   <= '0;
      len_q    <= '0;
      rnd_q    <= '0;
      fin_q    <= 1'b0;
      eom_q    <= 1'b0;
      pad80_q  <= 1'b0;
      lenblk_q <= 1'b0;
      oidx_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
    end else begin
      st_q <= st_d;
      case (st_q)
        StIdle: if (q_pop_o) begin
          eom_q <= q_item_i.end_of_message;
          if (put) begin
            fill_q <= fill_q + 6'd1;
            len_q  <= len_q + 61'd1;
          end
        end
        StPad: begin
          fill_q <= fill_q + 6'd1;
          if (!pad80_q) begin
            pad80_q  <= 1'b1;
            lenblk_q <= (fill_q < 6'd56);
          end
          if (fill_q == 6'd63) fin_q <= pad80_q && lenblk_q;
        end
        StRound: rnd_q <= rnd_q + 6'd1;
        StAdd: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
          // length spills into the next block
          if (!fin_q && eom_q) lenblk_q <= 1'b1;
        end
        StOut: if (out_if.ready) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
            fin_q    <= 1'b0;
            eom_q    <= 1'b0;
            pad80_q  <= 1'b0;
            lenblk_q <= 1'b0;
            fill_q   <= '0;
            len_q    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (put || st_q == StPad) begin
      w_q[fill_q[5:2]] <= {w_q[fill_q[5:2]][23:0], put_byte};
    end
    if ((put && fill_q == 6'd63) || (st_q == StPad && fill_q == 6'd63)) begin
      for (int i = 0; i < 8; i++) r_q[i] <= h_q[i];
    end
    if (st_q == StRound) begin
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
      if (rnd_q >= 6'd16) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= wn;
      end
    end
  end

  assign out_if.valid = (st_q == StOut);
  assign out_if.payload.digest_word = h_q[oidx_q];
  assign out_if.payload.word_index = oidx_q;
  assign out_if.payload.last_word = (oidx_q == 3'd7);

  `SHA_ASSERT_IMPL(a_out_only, clk_i, rst_ni, out_if.valid, st_q == StOut)
  `SHA_ASSERT_NEXT(a_idx_step, clk_i, rst_ni, out_if.valid && out_if.ready,
                   oidx_q == $past(oidx_q) + 3'd1)
  `SHA_ASSERT_IMPL(a_round_range, clk_i, rst_ni, st_q == StRound, fill_q == 6'd0)
endmodule

// ----- rtl/sha256_byte_stream_hasher.sv -----
// top level of the sha-256 byte stream hasher
// Usage:
//   in_if carries one transaction per message byte (data_byte, byte_valid)
//   and end_of_message marks the last transaction of a message; an end-only
//   transaction (byte_valid low) ends a message, also an empty one.
//   out_if delivers eight digest words, word_index 0 first, last_word high
//   on the eighth.
// Rate:
//   the block assembler takes bytes while idle; every 64th byte starts
//   the compression, 64 rounds plus one add step on one shared round
//   unit, and the assembler takes no bytes while the compression runs.
//   end of message: padding fills the block, then one compression, and
//   then the first word is offered; when the length spills into a second
//   block, a second padding block and compression come first. then eight
//   output transactions, one per cycle while out_if.ready is high.
//   a four-entry input queue lets input be taken while compression runs.
// Reset:
//   rst_ni clears the queue, loads the initial hash values and empties the
//   block; output stalls hold the current digest word and fill the queue.
module sha256_byte_stream_hasher #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input logic clk_i,
  input logic rst_ni,
  sha_in_if.sink    in_if,
  sha_out_if.source out_if
);
  import sha_pkg::*;

  logic         q_valid;
  in_item_t     q_item;
  logic         q_pop;

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .in_if,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_if
  );
endmodule

// ----- sim/sha256_byte_stream_hasher_tb.sv -----
// testbench for the sha-256 byte stream hasher with a reference digest predictor
module sha256_byte_stream_hasher_tb;
  import sha_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha256_byte_stream_hasher uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  in_item_t    pending_q [$];
  out_item_t   digest_q [$];
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [60:0] msg_len;
  int          mismatches = 0;
  int          accepted = 0;
  int          phase = 0;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;
  bit          stim_done = 1'b0;
  bit          in_taken = 1'b0;

  function automatic logic [31:0] ror32(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) r[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (ror32(r[4], 6) ^ ror32(r[4], 11) ^ ror32(r[4], 25)) +
           ((r[4] & r[5]) ^ (~r[4] & r[6])) + RoundK[i] + w[i];
      t2 = (ror32(r[0], 2) ^ ror32(r[0], 13) ^ ror32(r[0], 22)) +
           ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + r[i];
  endtask

  task automatic absorb_byte(logic [7:0] b);
    blk[fill] = b;
    fill = fill + 6'd1;
    if (fill == 6'd0) compress_block();
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) chain[i] = InitH[i];
    fill = '0;
    msg_len = '0;
  endtask

  task automatic add_item(in_item_t it);
    pending_q = {pending_q, it};
  endtask

  task automatic predict_digest(in_item_t it);
    logic [63:0] bits;
    out_item_t   o;
    if (it.byte_valid) begin
      absorb_byte(it.data_byte);
      msg_len = msg_len + 61'd1;
    end
    if (it.end_of_message) begin
      bits = {msg_len, 3'b000};
      absorb_byte(8'h80);
      while (fill != 6'd56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(bits[(7-i)*8 +: 8]);
      for (int i = 0; i < 8; i++) begin
        o.digest_word = chain[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == 7);
        digest_q = {digest_q, o};
      end
      restart_message();
    end
  endtask

  function automatic in_item_t mk(logic [7:0] d, logic bv, logic eom);
    in_item_t it;
    it.data_byte = d;
    it.byte_valid = bv;
    it.end_of_message = eom;
    return it;
  endfunction

  // acceptance and prediction
  always @(posedge clk_i) begin
    in_taken = 1'b0;
    if (rst_ni && in_if.valid && in_if.ready) begin
      predict_digest(in_if.payload);
      accepted++;
      in_taken = 1'b1;
      phase = (accepted < 90) ? 0 : ((accepted < 180) ? 1 : 2);
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.payload <= '0;
    end else if (!in_if.valid || in_taken) begin
      if (pending_q.size() != 0 &&
          !(phase == 0 && $urandom_range(99) < 10) &&
          !(phase == 1 && $urandom_range(99) < 76)) begin
        in_if.valid <= 1'b1;
        in_if.payload <= pending_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && accepted >= 120) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !((phase == 0 && $urandom_range(99) < 76) ||
                        (phase == 1 && $urandom_range(99) < 10));
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t exp_o;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h", out_if.payload);
      end else begin
        exp_o = digest_q.pop_front();
        if (out_if.payload.digest_word !== exp_o.digest_word ||
            out_if.payload.word_index !== exp_o.word_index ||
            out_if.payload.last_word !== exp_o.last_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected word %h idx %0d last %b, got %h idx %0d last %b",
                     exp_o.digest_word, exp_o.word_index, exp_o.last_word,
                     out_if.payload.digest_word, out_if.payload.word_index,
                     out_if.payload.last_word);
        end
      end
    end
  end

  initial begin
    int n;
    int len;
    int sel;
    restart_message();
    // empty message, single bytes at both extremes, ignored data, abc
    add_item(mk(8'h5a, 1'b0, 1'b1));
    add_item(mk(8'hff, 1'b1, 1'b1));
    add_item(mk(8'h00, 1'b1, 1'b0));
    add_item(mk(8'hff, 1'b0, 1'b0));
    add_item(mk(8'hc3, 1'b0, 1'b1));
    add_item(mk(8'h61, 1'b1, 1'b0));
    add_item(mk(8'h62, 1'b1, 1'b0));
    add_item(mk(8'h63, 1'b1, 1'b1));
    add_item(mk(8'h00, 1'b0, 1'b0));
    add_item(mk(8'h00, 1'b0, 1'b1));
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    n = 0;
    while (n < 260) begin
      sel = $urandom_range(99);
      if (sel < 70) len = $urandom_range(0, 20);
      else if (sel < 92) len = $urandom_range(50, 70);
      else len = $urandom_range(115, 130);
      if (len > 260 - n) len = 260 - n;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(99) < 5) begin
          add_item(mk(8'($urandom), 1'b0, 1'b0));
          n++;
        end
        add_item(mk(8'($urandom), 1'b1,
                    (i == len - 1) && $urandom_range(1)));
        n++;
      end
      if (len == 0 || !pending_q[$].end_of_message) begin
        add_item(mk(8'($urandom), 1'b0, 1'b1));
        n++;
      end
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending_q.size() != 0 || in_if.valid) @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && digest_q.size() == 0) $display("sha256_byte_stream_hasher_tb passed");
    else $display("sha256_byte_stream_hasher_tb failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("sha256_byte_stream_hasher_tb failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha_if.sv
rtl/sha_queue.sv
rtl/sha_core.sv
rtl/sha256_byte_stream_hasher.sv
sim/sha256_byte_stream_hasher_tb.sv
